[rtl/d64su_pkg.sv]
// package for the 64-bit signed/unsigned restoring divider
// holds the data word width, constants and the per-stage payload struct
// no dependencies
`timescale 1ns / 1ps

package d64su_pkg;

    localparam int unsigned W = 64;

    localparam logic [W-1:0] C_ONE  = {{(W-1){1'b0}}, 1'b1};
    localparam logic [W-1:0] C_ZERO = {W{1'b0}};

    // payload that moves down the divide pipeline with each item
    typedef struct packed {
        logic         neg;   // negate the magnitude quotient at the end
        logic         one;   // signed zero divisor with negative dividend
        logic [W-1:0] den;   // divisor magnitude
        logic [W-1:0] rem;   // partial remainder
        logic [W-1:0] nq;    // dividend bits still to shift in, quotient bits behind
    } t_stage;

endpackage

[rtl/d64su_front.sv]
// input stage of the divider: operand magnitudes and sign fix-up flags
// depends on d64su_pkg
`timescale 1ns / 1ps

module d64su_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic                    i_action,
    input  logic [d64su_pkg::W-1:0] i_dividend,
    input  logic [d64su_pkg::W-1:0] i_divisor,
    output logic                    o_valid,
    output d64su_pkg::t_stage       o_stage
);
    import d64su_pkg::*;

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;
    logic   w_num_neg;
    logic   w_den_neg;

    always_comb begin
        w_num_neg     = i_action & i_dividend[W-1];
        w_den_neg     = i_action & i_divisor[W-1];
        n_stage.rem   = C_ZERO;
        n_stage.nq    = w_num_neg ? (C_ZERO - i_dividend) : i_dividend;
        n_stage.den   = w_den_neg ? (C_ZERO - i_divisor) : i_divisor;
        n_stage.neg   = w_num_neg ^ w_den_neg;
        n_stage.one   = w_num_neg & (i_divisor == C_ZERO);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

[rtl/d64su_step.sv]
// one restoring division step: one quotient bit per register stage
// depends on d64su_pkg
`timescale 1ns / 1ps

module d64su_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  d64su_pkg::t_stage i_stage,
    output logic              o_valid,
    output d64su_pkg::t_stage o_stage
);
    import d64su_pkg::*;

    logic         r_valid;
    t_stage       r_stage;
    t_stage       n_stage;
    logic [W:0]   w_trial;
    logic [W:0]   w_diff;

    always_comb begin
        // shifted remainder keeps its carry-out as bit W
        w_trial = {i_stage.rem, i_stage.nq[W-1]};
        w_diff  = w_trial - {1'b0, i_stage.den};
        n_stage = i_stage;
        if (!w_diff[W]) begin
            n_stage.rem = w_diff[W-1:0];
            n_stage.nq  = {i_stage.nq[W-2:0], 1'b1};
        end else begin
            n_stage.rem = w_trial[W-1:0];
            n_stage.nq  = {i_stage.nq[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

[rtl/d64su_out.sv]
// output stage: quotient sign fix-up, output register and skid register
// depends on d64su_pkg
`timescale 1ns / 1ps

module d64su_out (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  d64su_pkg::t_stage       i_stage,
    input  logic                    i_stall,
    output logic                    o_en,
    output logic                    o_valid,
    output logic [d64su_pkg::W-1:0] o_quotient
);
    import d64su_pkg::*;

    logic         r_out_valid;
    logic [W-1:0] r_out_q;
    logic         r_skid_valid;
    logic [W-1:0] r_skid_q;
    logic [W-1:0] w_res;
    logic         w_push;

    always_comb begin
        if (i_stage.one) begin
            w_res = C_ONE;
        end else if (i_stage.neg) begin
            w_res = C_ZERO - i_stage.nq;
        end else begin
            w_res = i_stage.nq;
        end
    end

    assign w_push = i_valid & ~r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_skid_valid) begin
            if (!r_out_valid || !i_stall) begin
                r_out_valid <= w_push;
            end else if (w_push) begin
                r_skid_valid <= 1'b1;
            end
        end else if (!i_stall) begin
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            if (!r_out_valid || !i_stall) begin
                r_out_q <= w_res;
            end else begin
                r_skid_q <= w_res;
            end
        end else if (!i_stall) begin
            r_out_q <= r_skid_q;
        end
    end

    assign o_en       = ~r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_quotient = r_out_q;

endmodule

[rtl/div64_signed_unsigned_core.sv]
// top level of the pipelined 64-bit signed/unsigned restoring divider
// depends on d64su_pkg, d64su_front, d64su_step and d64su_out
`timescale 1ns / 1ps

// channel   direction  valid     stall     payload
// input     in         i_valid   o_stall   i_action, i_dividend, i_divisor
// output    out        o_valid   i_stall   o_quotient
//
// one item enters per cycle while o_stall is low; the pipeline is one operand stage,
// 64 restoring steps (one quotient bit per stage) and the output register
// reset is synchronous and active low; it clears only the valid bits
// the pipeline moves as a whole; a skid register behind the output register
// catches the item in flight when the output stalls, and o_stall comes
// straight from that register, so no path runs from i_stall to o_stall

module div64_signed_unsigned_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_action,
    input  logic [d64su_pkg::W-1:0] i_dividend,
    input  logic [d64su_pkg::W-1:0] i_divisor,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [d64su_pkg::W-1:0] o_quotient
);
    import d64su_pkg::*;

    // pipeline enable, low while the skid register holds an item
    logic   w_en;

    // stage links: index 0 is the operand stage, index W the last step
    logic   w_valid [0:W];
    t_stage w_stage [0:W];

    // magnitudes in signed mode, raw patterns in unsigned mode
    d64su_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_valid),
        .i_action   (i_action),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (w_valid[0]),
        .o_stage    (w_stage[0])
    );

    // one quotient bit per stage, most significant bit first
    genvar g;
    generate
        for (g = 0; g < W; g++) begin : g_step
            d64su_step u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (w_valid[g]),
                .i_stage (w_stage[g]),
                .o_valid (w_valid[g+1]),
                .o_stage (w_stage[g+1])
            );
        end
    endgenerate

    // sign fix-up and special cases, then output and skid registers
    d64su_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid[W]),
        .i_stage    (w_stage[W]),
        .i_stall    (i_stall),
        .o_en       (w_en),
        .o_valid    (o_valid),
        .o_quotient (o_quotient)
    );

    assign o_stall = ~w_en;

`ifndef SYNTHESIS
    // the skid register only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid register full while output register empty");

    // a full skid register drains in the first cycle the output moves
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && !i_stall) |=> (!o_stall && o_valid))
        else $error("skid register did not drain into the output");

    // reset leaves no item at the output and no stall at the input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("reset did not clear the output side");
`endif

endmodule

[sim/testbench.sv]
// self-checking testbench for the pipelined 64-bit signed/unsigned restoring divider
// depends on d64su_pkg and div64_signed_unsigned_core; predicts every quotient itself
`timescale 1ns / 1ps

module testbench;

    import d64su_pkg::*;

    // action codes carried on i_action
    localparam bit ACT_UNSIGNED = 1'b0;
    localparam bit ACT_SIGNED   = 1'b1;

    localparam logic [W-1:0] INT_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] INT_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ALL_ONES = {W{1'b1}};

    // pipeline depth from the top-level notes, plus slack for the skid register
    localparam int DRAIN_CYCLES = 80;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_valid    = 1'b0;
    logic         i_action   = ACT_UNSIGNED;
    logic [W-1:0] i_dividend = C_ZERO;
    logic [W-1:0] i_divisor  = C_ZERO;
    logic         i_stall    = 1'b0;
    logic         o_stall;
    logic         o_valid;
    logic [W-1:0] o_quotient;

    // quotients still owed by the block, oldest first
    logic [W-1:0] quotient_q[$];

    int unsigned idle_pct     = 0;   // chance per cycle that the sender sits idle
    int unsigned stall_pct    = 0;   // chance per cycle that the receiver stalls
    int          hold_left    = 0;   // cycles left in a long receiver hold-off
    int unsigned err_count    = 0;
    int unsigned sent_count   = 0;
    int unsigned signed_count = 0;
    int unsigned zero_count   = 0;
    int unsigned result_count = 0;
    int unsigned full_cycles  = 0;   // cycles during which the block pushed back

    div64_signed_unsigned_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_action   (i_action),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_quotient (o_quotient)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // plain restoring division on unsigned patterns, msb first;
    // a 65-bit partial remainder absorbs the bit shifted out at the top
    function automatic logic [W-1:0] restoring_udiv(input logic [W-1:0] num,
                                                    input logic [W-1:0] den);
        logic [W:0]   part;
        logic [W-1:0] quo;
        if (den == C_ZERO) begin
            return ALL_ONES;
        end
        part = '0;
        quo  = C_ZERO;
        for (int i = W - 1; i >= 0; i--) begin
            part = {part[W-1:0], num[i]};
            if (part >= {1'b0, den}) begin
                part   = part - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [W-1:0] predict_quotient(input bit           act,
                                                      input logic [W-1:0] num,
                                                      input logic [W-1:0] den);
        logic         num_neg;
        logic         den_neg;
        logic [W-1:0] mag_q;
        if (act == ACT_UNSIGNED) begin
            return restoring_udiv(num, den);
        end
        num_neg = num[W-1];
        den_neg = den[W-1];
        mag_q   = restoring_udiv(num_neg ? -num : num, den_neg ? -den : den);
        // a magnitude of 2^63 stays the most negative value whatever the signs
        if (mag_q == INT_MIN) begin
            return INT_MIN;
        end
        if (num_neg != den_neg) begin
            // only a zero divisor gives a magnitude above 2^63: that case reads +1
            return (mag_q < INT_MIN) ? -mag_q : C_ONE;
        end
        return (mag_q > INT_MIN) ? ALL_ONES : mag_q;
    endfunction

    // ---------------------------------------------------------------
    // receiver: random stalls, with an optional long hold-off on top
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("[%0t] error: %s", $time, what);
    endtask

    // result checker: every accepted quotient is matched against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_stall) begin
            full_cycles++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (quotient_q.size() == 0) begin
                report_mismatch($sformatf("quotient %h with none expected", o_quotient));
            end else if (o_quotient !== quotient_q[0]) begin
                report_mismatch($sformatf("quotient %h, expected %h",
                                          o_quotient, quotient_q[0]));
                void'(quotient_q.pop_front());
            end else begin
                void'(quotient_q.pop_front());
            end
        end
    end

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------

    // offer one division and hold it until the block takes it
    task automatic send_division(input bit           act,
                                 input logic [W-1:0] num,
                                 input logic [W-1:0] den);
        while ($urandom_range(0, 99) < idle_pct) begin
            // idle cycles carry junk on the payload
            i_valid    <= 1'b0;
            i_action   <= 1'($urandom_range(0, 1));
            i_dividend <= {$urandom, $urandom};
            i_divisor  <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= act;
        i_dividend <= num;
        i_divisor  <= den;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        quotient_q.push_back(predict_quotient(act, num, den));
        sent_count++;
        if (act == ACT_SIGNED) begin
            signed_count++;
        end
        if (den == C_ZERO) begin
            zero_count++;
        end
    endtask

    // operand with a random significant width and a random sign;
    // now and then one of the corner patterns
    function automatic logic [W-1:0] random_operand(input int unsigned max_shift);
        logic [W-1:0] val;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: val = C_ZERO;
                    1: val = C_ONE;
                    2: val = ALL_ONES;
                    3: val = INT_MIN;
                    4: val = INT_MAX;
                    default: val = -C_ONE - C_ONE;
                endcase
            end
            default: begin
                val = {$urandom, $urandom} >> $urandom_range(0, max_shift);
                if ($urandom_range(0, 2) == 0) begin
                    val = -val;
                end
            end
        endcase
        return val;
    endfunction

    task automatic run_random(input int unsigned count);
        for (int n = 0; n < count; n++) begin
            send_division(1'($urandom_range(0, 1)), random_operand(16), random_operand(63));
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // field extremes and every special case of both modes, back to back
    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_division(ACT_UNSIGNED, ALL_ONES, C_ONE);
        send_division(ACT_UNSIGNED, ALL_ONES, ALL_ONES);
        send_division(ACT_UNSIGNED, C_ZERO, ALL_ONES);
        send_division(ACT_UNSIGNED, 64'd5, C_ZERO);          // zero divisor, all ones
        send_division(ACT_UNSIGNED, ALL_ONES, C_ZERO);
        send_division(ACT_UNSIGNED, INT_MIN, 64'd2);
        send_division(ACT_UNSIGNED, 64'd100, 64'd7);
        send_division(ACT_SIGNED, 64'd7, C_ZERO);            // zero divisor, -1
        send_division(ACT_SIGNED, C_ZERO, C_ZERO);
        send_division(ACT_SIGNED, -64'd7, C_ZERO);           // negative over zero, +1
        send_division(ACT_SIGNED, INT_MIN, C_ZERO);
        send_division(ACT_SIGNED, INT_MIN, C_ONE);           // magnitude 2^63
        send_division(ACT_SIGNED, INT_MIN, ALL_ONES);        // wraps to the most negative value
        send_division(ACT_SIGNED, INT_MIN, 64'd2);
        send_division(ACT_SIGNED, INT_MAX, ALL_ONES);
        send_division(ACT_SIGNED, -64'd100, 64'd7);
        send_division(ACT_SIGNED, 64'd100, -64'd7);
        send_division(ACT_SIGNED, -64'd100, -64'd7);
        send_division(ACT_SIGNED, INT_MAX, INT_MIN);
        send_division(ACT_SIGNED, ALL_ONES, INT_MIN);
        send_division(ACT_SIGNED, INT_MIN, INT_MIN);
        send_division(ACT_SIGNED, INT_MAX, INT_MAX);
    endtask

    task automatic test_streaming();
        idle_pct  = 0;
        stall_pct = 0;
        run_random(250);
    endtask

    task automatic test_sender_gaps();
        idle_pct  = 58;
        stall_pct = 0;
        run_random(250);
    endtask

    task automatic test_receiver_stalls();
        idle_pct  = 0;
        stall_pct = 58;
        run_random(250);
    endtask

    task automatic test_both_sides_idle();
        idle_pct  = 38;
        stall_pct = 38;
        run_random(250);
    endtask

    // receiver holds off long enough for the pipeline and skid register to
    // fill, so the block has to push back on the sender
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 250;
        run_random(150);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_sides_idle();
        test_backpressure();

        i_valid <= 1'b0;
        stall_pct = 20;
        while (quotient_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d quotients from %0d divisions (%0d signed, %0d by zero)",
                 result_count, sent_count, signed_count, zero_count);
        $display("idle and stall phases plus a long hold-off; block pushed back %0d cycles",
                 full_cycles);
        if (err_count == 0) begin
            $display("div64_signed_unsigned_core: match");
        end else begin
            $display("div64_signed_unsigned_core: mismatch");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #(400_000 * 20);
        $display("timeout with %0d quotients outstanding", quotient_q.size());
        $display("div64_signed_unsigned_core: mismatch");
        $finish;
    end

endmodule

[files.f]
rtl/d64su_pkg.sv
rtl/d64su_front.sv
rtl/d64su_step.sv
rtl/d64su_out.sv
rtl/div64_signed_unsigned_core.sv
sim/testbench.sv
